### rtl/sexagesimal_angle_time_converter_defines.svh
// ----------------------------------------------------------------------------
// Sexagesimal angle/time converter assertion macros
// Immediate-consequence and next-cycle property wrappers, clocked on clk and
// disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SEXAGESIMAL_ANGLE_TIME_CONVERTER_DEFINES_SVH
`define SEXAGESIMAL_ANGLE_TIME_CONVERTER_DEFINES_SVH

// check cons in the same cycle as ante
`define SACT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define SACT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sact_pkg.sv
// ----------------------------------------------------------------------------
// sact_pkg
// Codes, constants, per-kind range table and shared types of the
// sexagesimal angle/time converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sact_pkg;

  localparam int NUM_STAGES  = 12;
  localparam int WRAP_FIRST  = 2;
  localparam int WRAP_STAGES = 4;
  localparam int SPLIT_FIRST = 6;
  localparam int SPLIT_STAGES = 5;

  localparam logic OP_PACK   = 1'b0;
  localparam logic OP_UNPACK = 1'b1;

  localparam logic [2:0] KIND_DEC  = 3'd0;
  localparam logic [2:0] KIND_ALT  = 3'd1;
  localparam logic [2:0] KIND_AZM  = 3'd2;
  localparam logic [2:0] KIND_TIME = 3'd3;
  localparam logic [2:0] KIND_RA   = 3'd4;
  localparam logic [2:0] KIND_HA   = 3'd5;

  localparam longint ASEC_HALF = 648000;
  localparam longint ASEC_FULL = 1296000;
  localparam longint MS_DAY    = 86400000;
  localparam longint MS_HALF   = 43200000;

  localparam longint ASEC_PER_DEG = 3600;
  localparam longint BASE60       = 60;
  localparam longint MS_PER_HOUR  = 3600000;
  localparam longint MS_PER_MIN   = 60000;
  localparam longint MS_PER_SEC   = 1000;

  localparam longint DEG_HALF      = 180;
  localparam longint DEG_FULL      = 360;
  localparam longint HOURS_PER_DAY = 24;

  localparam longint TWO_POW_31 = longint'(1) << 31;
  localparam longint TWO_POW_32 = longint'(1) << 32;

  // floor(2^32 / period): quotient estimate is exact or one low
  localparam logic [11:0] RCP_ASEC = 12'(TWO_POW_32 / ASEC_FULL);
  localparam logic [11:0] RCP_MS   = 12'(TWO_POW_32 / MS_DAY);

  // (2^31 + (lo mod period)) mod period, undoes the input bias
  localparam logic [26:0] OFS_DEC  = 27'((TWO_POW_31 + ASEC_HALF) % ASEC_FULL);
  localparam logic [26:0] OFS_AZM  = 27'(TWO_POW_31 % ASEC_FULL);
  localparam logic [26:0] OFS_TIME = 27'(TWO_POW_31 % MS_DAY);
  localparam logic [26:0] OFS_HA   = 27'((TWO_POW_31 + MS_HALF) % MS_DAY);

  // exact reciprocal multipliers over the value ranges used
  localparam int          SHIFT_1000 = 37;
  localparam logic [27:0] MAGIC_1000 =
    28'(((longint'(1) << SHIFT_1000) + MS_PER_SEC - 1) / MS_PER_SEC);
  localparam int          SHIFT_60   = 27;
  localparam logic [21:0] MAGIC_60   =
    22'(((longint'(1) << SHIFT_60) + BASE60 - 1) / BASE60);

  typedef struct packed {
    logic              known;
    logic              timek;
    logic signed [27:0] lo;
    logic signed [27:0] hi;
    logic [26:0]       period;
    logic [11:0]       rcp;
    logic [26:0]       ofs;
    logic [8:0]        modv;
  } kind_info_t;

  typedef struct packed {
    logic       op;
    logic [2:0] kind;
  } tag_t;

  typedef struct packed {
    logic               neg;
    logic [8:0]         major;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [9:0]         milli;
    logic signed [27:0] total;
  } split_t;

  function automatic kind_info_t kind_info(input logic [2:0] kind_code);
    kind_info_t ki;
    ki = '0;
    unique case (kind_code) inside
      KIND_DEC, KIND_ALT: begin
        ki.known  = 1'b1;
        ki.timek  = 1'b0;
        ki.lo     = -28'(ASEC_HALF);
        ki.hi     = 28'(ASEC_HALF);
        ki.period = 27'(ASEC_FULL);
        ki.rcp    = RCP_ASEC;
        ki.ofs    = OFS_DEC;
        ki.modv   = 9'(DEG_HALF);
      end
      KIND_AZM: begin
        ki.known  = 1'b1;
        ki.timek  = 1'b0;
        ki.lo     = '0;
        ki.hi     = 28'(ASEC_FULL);
        ki.period = 27'(ASEC_FULL);
        ki.rcp    = RCP_ASEC;
        ki.ofs    = OFS_AZM;
        ki.modv   = 9'(DEG_FULL);
      end
      KIND_TIME, KIND_RA: begin
        ki.known  = 1'b1;
        ki.timek  = 1'b1;
        ki.lo     = '0;
        ki.hi     = 28'(MS_DAY);
        ki.period = 27'(MS_DAY);
        ki.rcp    = RCP_MS;
        ki.ofs    = OFS_TIME;
        ki.modv   = 9'(HOURS_PER_DAY);
      end
      KIND_HA: begin
        ki.known  = 1'b1;
        ki.timek  = 1'b1;
        ki.lo     = -28'(MS_HALF);
        ki.hi     = 28'(MS_HALF);
        ki.period = 27'(MS_DAY);
        ki.rcp    = RCP_MS;
        ki.ofs    = OFS_HA;
        ki.modv   = 9'(HOURS_PER_DAY);
      end
      default: begin
        ki = '0;
      end
    endcase
    return ki;
  endfunction

endpackage

`default_nettype wire

### rtl/sact_pack.sv
// ----------------------------------------------------------------------------
// sact_pack
// Weighted sum of the sexagesimal parts (arcseconds or milliseconds), or the
// raw total for an unpack request.
// ----------------------------------------------------------------------------
`default_nettype none

module sact_pack
  import sact_pkg::*;
(
  input  logic               opcode,
  input  logic [2:0]         kind,
  input  logic signed [9:0]  major_part,
  input  logic signed [7:0]  minute_part,
  input  logic signed [7:0]  second_part,
  input  logic signed [10:0] milli_part,
  input  logic signed [31:0] total_in,
  output logic signed [31:0] total
);

  kind_info_t         ki;
  logic signed [31:0] maj_w;
  logic signed [31:0] min_w;
  logic signed [31:0] sec_w;
  logic signed [31:0] ms_w;
  logic signed [31:0] ang_sum;
  logic signed [31:0] tim_sum;

  assign ki    = kind_info(kind);
  assign maj_w = 32'(major_part);
  assign min_w = 32'(minute_part);
  assign sec_w = 32'(second_part);
  assign ms_w  = 32'(milli_part);

  assign ang_sum = maj_w * 32'(ASEC_PER_DEG) + min_w * 32'(BASE60) + sec_w;
  assign tim_sum = maj_w * 32'(MS_PER_HOUR) + min_w * 32'(MS_PER_MIN)
                 + sec_w * 32'(MS_PER_SEC) + ms_w;

  assign total = (opcode == OP_UNPACK) ? total_in : (ki.timek ? tim_sum : ang_sum);

endmodule

`default_nettype wire

### rtl/sact_wrap.sv
// ----------------------------------------------------------------------------
// sact_wrap
// Four-stage range wrap: biased total, reciprocal quotient estimate,
// quotient times period, corrected remainder, then rebased onto the kind's
// inclusive range.
// ----------------------------------------------------------------------------
`default_nettype none

module sact_wrap
  import sact_pkg::*;
(
  input  logic                   clk,
  input  logic [WRAP_STAGES-1:0] en,
  input  tag_t                   tags [NUM_STAGES],
  input  logic signed [31:0]     total,
  output logic signed [27:0]     wrapped
);

  kind_info_t ki1;
  kind_info_t ki2;
  kind_info_t ki3;
  kind_info_t ki4;

  logic [31:0] u_in;
  logic [43:0] est_prod;
  logic        ge_in;
  logic [31:0] u_q2;
  logic [11:0] quo_q2;
  logic        ge_q2;

  logic [38:0] back_prod;
  logic [31:0] u_q3;
  logic [31:0] pq_q3;
  logic        ge_q3;

  logic [31:0] diff;
  logic [27:0] rem_raw;
  logic [27:0] rem_fix;
  logic [26:0] rem_q4;
  logic        ge_q4;

  logic [26:0]        delta;
  logic signed [27:0] cand;

  assign ki1 = kind_info(tags[WRAP_FIRST - 1].kind);
  assign ki2 = kind_info(tags[WRAP_FIRST].kind);
  assign ki3 = kind_info(tags[WRAP_FIRST + 1].kind);
  assign ki4 = kind_info(tags[WRAP_FIRST + 2].kind);

  assign u_in     = {~total[31], total[30:0]};
  assign est_prod = 44'(u_in) * 44'(ki1.rcp);
  assign ge_in    = total >= 32'(ki1.hi);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u_q2   <= u_in;
      quo_q2 <= est_prod[43:32];
      ge_q2  <= ge_in;
    end
  end

  assign back_prod = 39'(quo_q2) * 39'(ki2.period);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      u_q3  <= u_q2;
      pq_q3 <= back_prod[31:0];
      ge_q3 <= ge_q2;
    end
  end

  assign diff    = u_q3 - pq_q3;
  assign rem_raw = diff[27:0];
  assign rem_fix = (rem_raw >= 28'(ki3.period)) ? rem_raw - 28'(ki3.period) : rem_raw;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rem_q4 <= rem_fix[26:0];
      ge_q4  <= ge_q3;
    end
  end

  assign delta = (rem_q4 >= ki4.ofs) ? rem_q4 - ki4.ofs : rem_q4 + ki4.period - ki4.ofs;
  assign cand  = ki4.lo + signed'({1'b0, delta});

  always_ff @(posedge clk) begin
    if (en[3]) begin
      wrapped <= (ge_q4 && (delta == '0)) ? ki4.hi : cand;
    end
  end

endmodule

`default_nettype wire

### rtl/sact_split.sv
// ----------------------------------------------------------------------------
// sact_split
// Five-stage sexagesimal split of a wrapped total: magnitude and sign, then
// one constant-reciprocal division per stage with the remainder formed one
// stage later.
// ----------------------------------------------------------------------------
`default_nettype none

module sact_split
  import sact_pkg::*;
(
  input  logic                    clk,
  input  logic [SPLIT_STAGES-1:0] en,
  input  tag_t                    tags [NUM_STAGES],
  input  logic signed [27:0]      wrapped,
  output split_t                  parts
);

  localparam int ABS_W = 27;
  localparam int Q1_W  = 17;
  localparam int Q2_W  = 11;
  localparam int Q3_W  = 5;

  kind_info_t ki6;
  kind_info_t ki7;
  kind_info_t ki9;

  logic timek6;
  logic timek7;
  logic timek9;

  logic               neg_q6;
  logic [ABS_W-1:0]   abs_q6;
  logic signed [27:0] tot_q6;

  logic [54:0]        prod_ms;
  logic [48:0]        prod_as;
  logic               neg_q7;
  logic [Q1_W-1:0]    q1_q7;
  logic [9:0]         abs_lo_q7;
  logic signed [27:0] tot_q7;

  logic [9:0]         div1;
  logic [38:0]        prod_q2;
  logic               neg_q8;
  logic [9:0]         rem0_q8;
  logic [Q2_W-1:0]    q2_q8;
  logic [5:0]         q1_lo_q8;
  logic signed [27:0] tot_q8;

  logic [32:0]        prod_q3;
  logic               neg_q9;
  logic [9:0]         rem0_q9;
  logic [5:0]         rem1_q9;
  logic [Q2_W-1:0]    q2_q9;
  logic [Q3_W-1:0]    q3_q9;
  logic signed [27:0] tot_q9;

  logic [5:0]         rem2;

  assign ki6    = kind_info(tags[SPLIT_FIRST].kind);
  assign ki7    = kind_info(tags[SPLIT_FIRST + 1].kind);
  assign ki9    = kind_info(tags[SPLIT_FIRST + 3].kind);
  assign timek6 = ki6.timek;
  assign timek7 = ki7.timek;
  assign timek9 = ki9.timek;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg_q6 <= wrapped[27];
      abs_q6 <= wrapped[27] ? ABS_W'(-wrapped) : wrapped[ABS_W-1:0];
      tot_q6 <= wrapped;
    end
  end

  assign prod_ms = 55'(abs_q6) * 55'(MAGIC_1000);
  assign prod_as = 49'(abs_q6) * 49'(MAGIC_60);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg_q7    <= neg_q6;
      q1_q7     <= timek6 ? prod_ms[SHIFT_1000 +: Q1_W] : prod_as[SHIFT_60 +: Q1_W];
      abs_lo_q7 <= abs_q6[9:0];
      tot_q7    <= tot_q6;
    end
  end

  assign div1    = timek7 ? 10'(MS_PER_SEC) : 10'(BASE60);
  assign prod_q2 = 39'(q1_q7) * 39'(MAGIC_60);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      neg_q8   <= neg_q7;
      rem0_q8  <= abs_lo_q7 - 10'(10'(q1_q7) * div1);
      q2_q8    <= prod_q2[SHIFT_60 +: Q2_W];
      q1_lo_q8 <= q1_q7[5:0];
      tot_q8   <= tot_q7;
    end
  end

  assign prod_q3 = 33'(q2_q8) * 33'(MAGIC_60);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      neg_q9  <= neg_q8;
      rem0_q9 <= rem0_q8;
      rem1_q9 <= q1_lo_q8 - 6'(q2_q8[5:0] * 6'(BASE60));
      q2_q9   <= q2_q8;
      q3_q9   <= prod_q3[SHIFT_60 +: Q3_W];
      tot_q9  <= tot_q8;
    end
  end

  assign rem2 = q2_q9[5:0] - 6'(6'(q3_q9) * 6'(BASE60));

  always_ff @(posedge clk) begin
    if (en[4]) begin
      parts.neg    <= neg_q9;
      parts.major  <= timek9 ? 9'(q3_q9) : q2_q9[8:0];
      parts.minute <= timek9 ? rem2 : rem1_q9;
      parts.second <= timek9 ? rem1_q9 : rem0_q9[5:0];
      parts.milli  <= timek9 ? rem0_q9 : '0;
      parts.total  <= tot_q9;
    end
  end

endmodule

`default_nettype wire

### rtl/sexagesimal_angle_time_converter.sv
// ----------------------------------------------------------------------------
// sexagesimal_angle_time_converter
// Converts between degrees/hours, minutes, seconds and milliseconds and a
// single arcsecond or millisecond total, in either direction, with the total
// wrapped into the range of the selected kind (both bounds inclusive).
// The block is a twelve-stage pipeline that takes one request per clock when
// the result side does not stall. Most of its stages belong to the range wrap
// (a reciprocal quotient estimate, its back-multiplication and two correction
// stages) and the digit split (one constant-reciprocal division per stage).
// Empty stages close up under a stall, so requests keep entering until every
// stage holds one. Unused kind codes give an all-zero result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sexagesimal_angle_time_converter_defines.svh"

module sexagesimal_angle_time_converter
  import sact_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic               opcode,
  input  logic [2:0]         kind,
  input  logic signed [9:0]  major_part,
  input  logic signed [7:0]  minute_part,
  input  logic signed [7:0]  second_part,
  input  logic signed [10:0] milli_part,
  input  logic signed [31:0] total_in,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [27:0] total_out,
  output logic signed [9:0]  major_out,
  output logic signed [6:0]  minute_out,
  output logic signed [6:0]  second_out,
  output logic signed [10:0] milli_out
);

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] en;
  tag_t                  tag_q [NUM_STAGES];

  logic signed [9:0]  major_q;
  logic signed [7:0]  minute_q;
  logic signed [7:0]  second_q;
  logic signed [10:0] milli_q;
  logic signed [31:0] total_q;

  logic signed [31:0] sum;
  logic signed [31:0] sum_q;
  logic signed [27:0] wrapped;
  split_t             parts;

  kind_info_t         ki_last;
  logic [8:0]         major_red;
  logic signed [9:0]  major_mag;
  logic signed [6:0]  minute_mag;
  logic signed [6:0]  second_mag;
  logic signed [10:0] milli_mag;
  logic               do_pack;
  logic               do_unpack;

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !res_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  assign req_stall = !en[0];
  assign res_valid = valid_q[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= req_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tag_q[0].op   <= opcode;
      tag_q[0].kind <= kind;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (en[i]) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      major_q  <= major_part;
      minute_q <= minute_part;
      second_q <= second_part;
      milli_q  <= milli_part;
      total_q  <= total_in;
    end
  end

  sact_pack u_pack (
    .opcode      (tag_q[0].op),
    .kind        (tag_q[0].kind),
    .major_part  (major_q),
    .minute_part (minute_q),
    .second_part (second_q),
    .milli_part  (milli_q),
    .total_in    (total_q),
    .total       (sum)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sum_q <= sum;
    end
  end

  sact_wrap u_wrap (
    .clk     (clk),
    .en      (en[WRAP_FIRST +: WRAP_STAGES]),
    .tags    (tag_q),
    .total   (sum_q),
    .wrapped (wrapped)
  );

  sact_split u_split (
    .clk     (clk),
    .en      (en[SPLIT_FIRST +: SPLIT_STAGES]),
    .tags    (tag_q),
    .wrapped (wrapped),
    .parts   (parts)
  );

  assign ki_last    = kind_info(tag_q[NUM_STAGES-2].kind);
  assign do_pack    = ki_last.known && (tag_q[NUM_STAGES-2].op == OP_PACK);
  assign do_unpack  = ki_last.known && (tag_q[NUM_STAGES-2].op == OP_UNPACK);
  assign major_red  = (parts.major >= ki_last.modv) ? parts.major - ki_last.modv : parts.major;
  assign major_mag  = signed'({1'b0, major_red});
  assign minute_mag = signed'({1'b0, parts.minute});
  assign second_mag = signed'({1'b0, parts.second});
  assign milli_mag  = signed'({1'b0, parts.milli});

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      total_out  <= do_pack ? parts.total : '0;
      major_out  <= !do_unpack ? '0 : (parts.neg ? -major_mag : major_mag);
      minute_out <= !do_unpack ? '0 : (parts.neg ? -minute_mag : minute_mag);
      second_out <= !do_unpack ? '0 : (parts.neg ? -second_mag : second_mag);
      milli_out  <= !do_unpack ? '0 : (parts.neg ? -milli_mag : milli_mag);
    end
  end

  `SACT_ASSERT_NOW(a_stall_only_when_full,
    req_stall,
    valid_q[0] && valid_q[NUM_STAGES-1] && res_stall,
    "request stalled while the pipeline can still move")

  `SACT_ASSERT_NEXT(a_result_drains,
    res_valid && !res_stall && !valid_q[NUM_STAGES-2],
    !res_valid,
    "result valid without a request behind it")

  `SACT_ASSERT_NOW(a_pack_parts_zero,
    res_valid && (tag_q[NUM_STAGES-1].op == OP_PACK),
    (major_out == '0) && (minute_out == '0) && (second_out == '0) && (milli_out == '0),
    "pack result carries nonzero parts")

  `SACT_ASSERT_NOW(a_unpack_total_zero,
    res_valid && (tag_q[NUM_STAGES-1].op == OP_UNPACK),
    total_out == '0,
    "unpack result carries a nonzero total")

  `SACT_ASSERT_NOW(a_unused_kind_zero,
    res_valid && (tag_q[NUM_STAGES-1].kind > KIND_HA),
    (total_out == '0) && (major_out == '0) && (minute_out == '0) && (second_out == '0),
    "unused kind code gives a nonzero result")

endmodule

`default_nettype wire
